/* sv/iotlm_pkg.sv */
// ----------------------------------------------------------------------------
// iotlm_pkg
// Shared widths, constants and controller/datapath interface types for the
// I/O throughput level monitor.
// ----------------------------------------------------------------------------
package iotlm_pkg;

	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 48;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam int unsigned DIVIDEND_W = 54;
	localparam int unsigned DIV_CNT_W  = 6;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_DELAY     = 2'd2;

	localparam logic [15:0] INTERVAL_MS_RST    = 16'd1000;
	localparam logic [31:0] INTERVAL_BYTES_RST = 32'd104857600;
	localparam logic [15:0] ZERO_DELAY_RST     = 16'd2000;

	localparam logic [30:0] TPUT_MAX   = 31'h7FFF_FFFF;
	localparam logic [31:0] LEVEL_STEP = 32'd100;
	localparam logic [7:0]  OP_READ    = 8'd0;
	localparam logic [7:0]  OP_WRITE   = 8'd1;
	localparam logic        KIND_TICK  = 1'b1;
	localparam logic [4:0]  LEVEL_MAX  = 5'd25;

	typedef struct packed {
		logic load_item;
		logic add_step;
		logic diff;
		logic div_init;
		logic div_step;
		logic sat;
		logic lvl_step;
		logic apply;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic counted;
		logic trigger;
		logic lvl_done;
		logic out_free;
	} dp_sts_t;

endpackage

/* sv/iotlm_ctrl.sv */
// ----------------------------------------------------------------------------
// iotlm_ctrl
// Sequencer: steps one item through count, trigger test, divide, level
// search, notice update and result hand-off.
// ----------------------------------------------------------------------------
module iotlm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  iotlm_pkg::dp_sts_t sts,
	output iotlm_pkg::dp_cmd_t cmd
);
	import iotlm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_CHECK,
		ST_TEST,
		ST_MUL,
		ST_DIV,
		ST_SAT,
		ST_LVL,
		ST_APPLY,
		ST_FIN
	} state_t;

	state_t                 state_q;
	logic [DIV_CNT_W-1:0]   div_cnt_q;

	assign s_axis_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.load_item = (state_q == ST_IDLE) && s_axis_tvalid;
		cmd.add_step  = (state_q == ST_ADD);
		cmd.diff      = (state_q == ST_CHECK);
		cmd.div_init  = (state_q == ST_MUL);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.sat       = (state_q == ST_SAT);
		cmd.lvl_step  = (state_q == ST_LVL);
		cmd.apply     = (state_q == ST_APPLY);
		cmd.out_load  = (state_q == ST_FIN) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (sts.is_tick || !sts.counted) state_q <= ST_FIN;
					else state_q <= ST_CHECK;
				end
				ST_CHECK: state_q <= ST_TEST;
				ST_TEST: begin
					if (sts.trigger) state_q <= ST_MUL;
					else state_q <= ST_FIN;
				end
				ST_MUL: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_LAST) state_q <= ST_SAT;
				end
				ST_SAT: state_q <= ST_LVL;
				ST_LVL: begin
					if (sts.lvl_done) state_q <= ST_APPLY;
				end
				ST_APPLY: state_q <= ST_FIN;
				ST_FIN: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* sv/iotlm_dp.sv */
// ----------------------------------------------------------------------------
// iotlm_dp
// Datapath: configuration registers, byte and tick counters, bit-serial
// restoring divider, iterative level search, notice logic, result register.
// ----------------------------------------------------------------------------
module iotlm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [iotlm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [iotlm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic [iotlm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  logic [0:0]                          s_axis_tuser,
	input  iotlm_pkg::dp_cmd_t                  cmd,
	output iotlm_pkg::dp_sts_t                  sts,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [iotlm_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
	import iotlm_pkg::*;

	// configuration
	logic [15:0] interval_ms_q;
	logic [31:0] interval_bytes_q;
	logic [15:0] zero_delay_q;

	// item
	logic        kind_q;
	logic [7:0]  op_q;
	logic [31:0] bytes_q;

	// monitor state
	logic [63:0] total_q;
	logic [63:0] bau_q;
	logic [31:0] ms_q;
	logic [4:0]  level_q;
	logic [30:0] tput_q;
	logic        pend_q;
	logic [15:0] cnt_q;

	// per-item flags
	logic        nf_q;
	logic [4:0]  nl_q;
	logic        upd_q;

	// work registers
	logic [63:0]           diff_q;
	logic [DIVIDEND_W-1:0] dq_q;
	logic [31:0]           rem_q;
	logic [31:0]           div_q;
	logic [31:0]           thr_q;
	logic [4:0]            lvl_q;

	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic [43:0]           mib;
	logic [DIVIDEND_W-1:0] dividend;
	logic [32:0]           rem_sh;
	logic                  rem_ge;
	logic [15:0]           cnt_dec;
	logic                  lvl_ge;
	logic                  lvl_chg;

	assign mib      = diff_q[63:20];
	assign dividend = {mib, 10'b0} - {6'b0, mib, 4'b0} - {7'b0, mib, 3'b0};
	assign rem_sh   = {rem_q, dq_q[DIVIDEND_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, div_q};
	assign cnt_dec  = (cnt_q != 16'd0) ? cnt_q - 16'd1 : 16'd0;
	assign lvl_ge   = {1'b0, tput_q} >= thr_q;
	assign lvl_chg  = (level_q != 5'd0) != (lvl_q != 5'd0);

	assign sts.is_tick  = (kind_q == KIND_TICK);
	assign sts.counted  = (op_q <= OP_WRITE);
	assign sts.trigger  = (ms_q >= {16'b0, interval_ms_q}) ||
	                      (diff_q >= {32'b0, interval_bytes_q});
	assign sts.lvl_done = !lvl_ge;
	assign sts.out_free = !m_valid_q || m_axis_tready;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_ms_q    <= INTERVAL_MS_RST;
			interval_bytes_q <= INTERVAL_BYTES_RST;
			zero_delay_q     <= ZERO_DELAY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INTERVAL_MS:    interval_ms_q    <= cfg_wdata[15:0];
				REG_INTERVAL_BYTES: interval_bytes_q <= cfg_wdata;
				REG_ZERO_DELAY:     zero_delay_q     <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			bau_q     <= '0;
			ms_q      <= '0;
			level_q   <= '0;
			tput_q    <= '0;
			pend_q    <= 1'b0;
			cnt_q     <= '0;
			nf_q      <= 1'b0;
			nl_q      <= '0;
			upd_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				nf_q  <= 1'b0;
				nl_q  <= '0;
				upd_q <= 1'b0;
			end
			if (cmd.add_step) begin
				if (kind_q == KIND_TICK) begin
					if (ms_q != '1) ms_q <= ms_q + 32'd1;
					if (pend_q) begin
						cnt_q <= cnt_dec;
						if (cnt_dec == 16'd0) begin
							pend_q <= 1'b0;
							nf_q   <= 1'b1;
							nl_q   <= level_q;
						end
					end
				end else if (op_q <= OP_WRITE) begin
					total_q <= total_q + {32'b0, bytes_q};
				end
			end
			if (cmd.sat) begin
				tput_q <= (|dq_q[DIVIDEND_W-1:31]) ? TPUT_MAX : dq_q[30:0];
			end
			if (cmd.apply) begin
				upd_q   <= 1'b1;
				level_q <= lvl_q;
				bau_q   <= total_q;
				ms_q    <= '0;
				if (lvl_chg) begin
					if (lvl_q != 5'd0 || zero_delay_q == 16'd0) begin
						pend_q <= 1'b0;
						cnt_q  <= '0;
						nf_q   <= 1'b1;
						nl_q   <= lvl_q;
					end else begin
						pend_q <= 1'b1;
						cnt_q  <= zero_delay_q;
					end
				end
			end
			if (cmd.out_load) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q  <= s_axis_tuser[0];
			op_q    <= s_axis_tdata[7:0];
			bytes_q <= s_axis_tdata[39:8];
		end
		if (cmd.diff) diff_q <= total_q - bau_q;
		if (cmd.div_init) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= (ms_q == 32'd0) ? 32'd1 : ms_q;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? 32'(rem_sh - {1'b0, div_q}) : rem_sh[31:0];
			dq_q  <= {dq_q[DIVIDEND_W-2:0], rem_ge};
		end
		if (cmd.sat) begin
			thr_q <= LEVEL_STEP;
			lvl_q <= '0;
		end else if (cmd.lvl_step && lvl_ge) begin
			thr_q <= {thr_q[30:0], 1'b0};
			lvl_q <= lvl_q + 5'd1;
		end
		if (cmd.out_load) begin
			m_data_q <= {5'b0, upd_q, tput_q, level_q, nl_q, nf_q};
		end
	end

endmodule

/* sv/io_throughput_level_monitor_unit.sv */
// ----------------------------------------------------------------------------
// io_throughput_level_monitor_unit
// Tracks request bytes and millisecond ticks, derives throughput and level,
// and reports level notices.
// ----------------------------------------------------------------------------
// Sequence: a tick or an ignored request goes from the count step straight to the
//   result; a counted request adds the trigger test, and an update adds the
//   bit-serial divider, saturation, level search and notice update.
// One item in flight; the next beat is taken the cycle after the result is
//   loaded into the output register, which waits while a held result is not taken.
// Reset: arst_n clears monitor state and restores configuration defaults.
module io_throughput_level_monitor_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [iotlm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [iotlm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// op_code[7:0], byte_count[39:8]
	input  logic [iotlm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// kind[0]
	input  logic [0:0]                       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// notify[0], notify_level[5:1], level[10:6], throughput_mbps[41:11],
	// updated[42], zero[47:43]
	output logic [iotlm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import iotlm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	iotlm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	iotlm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cmd           (cmd),
		.sts           (sts),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second beat taken while an item is in progress");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten while held");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[10:6] <= LEVEL_MAX))
		else $error("level out of range");

endmodule
